[sv/quadrature_encoder_position_speed_core_macros.svh]
// ----------------------------------------------------------------------------
// Quadrature encoder core assertion macros
// Clocked assertion shorthands that compile away when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_ENCODER_POSITION_SPEED_CORE_MACROS_SVH
`define QUADRATURE_ENCODER_POSITION_SPEED_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define QEPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("qeps assertion failed");
`define QEPS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("qeps sequence assertion failed");
`else
`define QEPS_ASSERT(lbl, prop)
`define QEPS_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

[sv/qeps_pkg.sv]
// ----------------------------------------------------------------------------
// Quadrature encoder core package
// Field types, request and unit codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package qeps_pkg;

  localparam int NUM_ENC = 2;

  typedef logic [2:0]  req_type_t;
  typedef logic [1:0]  enc_sel_t;
  typedef logic [1:0]  unit_t;
  typedef logic signed [47:0] value_t;
  typedef logic [2:0]  dir_code_t;
  typedef logic [2:0]  cfg_idx_t;
  typedef logic [15:0] cfg_data_t;

  localparam req_type_t REQ_A_RISE = 3'd0;
  localparam req_type_t REQ_B_EDGE = 3'd1;
  localparam req_type_t REQ_TICK   = 3'd2;
  localparam req_type_t REQ_CLEAR  = 3'd3;

  localparam enc_sel_t SEL_ENC0 = 2'd0;
  localparam enc_sel_t SEL_ENC1 = 2'd1;
  localparam enc_sel_t SEL_BOTH = 2'd2;
  localparam enc_sel_t SEL_NONE = 2'd3;

  localparam unit_t UNIT_COUNTS = 2'd0;
  localparam unit_t UNIT_DEG    = 2'd1;
  localparam unit_t UNIT_CM     = 2'd2;
  localparam unit_t UNIT_M      = 2'd3;

  // Stored wheel direction.
  localparam logic [1:0] WDIR_CW  = 2'd0;
  localparam logic [1:0] WDIR_CCW = 2'd1;
  localparam logic [1:0] WDIR_UNK = 2'd2;

  localparam dir_code_t DIR_CW      = 3'd0;
  localparam dir_code_t DIR_CCW     = 3'd1;
  localparam dir_code_t DIR_FWD     = 3'd2;
  localparam dir_code_t DIR_BWD     = 3'd3;
  localparam dir_code_t DIR_TURN_R  = 3'd4;
  localparam dir_code_t DIR_TURN_L  = 3'd5;
  localparam dir_code_t DIR_UNKNOWN = 3'd6;

  localparam cfg_idx_t CFG_PPR   = 3'd0;
  localparam cfg_idx_t CFG_CIRC  = 3'd1;
  localparam cfg_idx_t CFG_IVL   = 3'd2;
  localparam cfg_idx_t CFG_CW0   = 3'd3;
  localparam cfg_idx_t CFG_CW1   = 3'd4;

  localparam logic [15:0] PPR_RST  = 16'd20;
  localparam logic [15:0] CIRC_RST = 16'd5120;
  localparam logic [15:0] IVL_RST  = 16'd100;

  // Unit scale factors, Q.8.
  localparam logic [26:0] K_COUNTS = 27'd256;
  localparam logic [26:0] K_DEG    = 27'd92160;

endpackage
`default_nettype wire

[sv/qeps_if.sv]
// ----------------------------------------------------------------------------
// Quadrature encoder core channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface qeps_req_if;
  import qeps_pkg::*;
  logic       valid;
  logic       ready;
  req_type_t  req_type;
  enc_sel_t   encoder_sel;
  unit_t      unit_format;
  modport source (output valid, req_type, encoder_sel, unit_format, input ready);
  modport sink   (input valid, req_type, encoder_sel, unit_format, output ready);
endinterface

interface qeps_res_if;
  import qeps_pkg::*;
  logic       valid;
  logic       ready;
  value_t     position_value;
  value_t     speed_value;
  dir_code_t  direction_code;
  modport source (output valid, position_value, speed_value, direction_code, input ready);
  modport sink   (input valid, position_value, speed_value, direction_code, output ready);
endinterface
`default_nettype wire

[sv/quadrature_encoder_position_speed_core.sv]
// ----------------------------------------------------------------------------
// Quadrature encoder position and speed core
// x1 decoding of two encoders with unit-converted position and speed readout.
// ----------------------------------------------------------------------------
// Sequence: a request runs two passes (position, speed), each of one load,
//   27 shift-add multiply steps, 60 restoring divide steps and one saturate
//   step, all on one shared 60-bit adder, then a hand-off to the result.
// Requests: one at a time; the request side is ready only idle.
// Reset: counts, deltas and B levels clear, directions go unknown, registers
//   take their default values.
`timescale 1ns / 1ps
`default_nettype none
`include "quadrature_encoder_position_speed_core_macros.svh"
module quadrature_encoder_position_speed_core (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  qeps_pkg::cfg_idx_t   cfg_idx_i,
  input  qeps_pkg::cfg_data_t  cfg_wdata_i,
  qeps_req_if.sink             req,
  qeps_res_if.source           res
);
  import qeps_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_SAT  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  localparam logic [5:0] MUL_STEPS = 6'd27;
  localparam logic [5:0] DIV_STEPS = 6'd60;
  localparam logic [59:0] POS_LIM = 60'h0007FFFFFFFFFFF;
  localparam logic [59:0] NEG_LIM = 60'h000800000000000;

  logic [15:0] ppr_q, circ_q, ivl_q;
  logic [NUM_ENC-1:0] cw_q;
  logic [31:0] pc_q [NUM_ENC];
  logic [31:0] last_q [NUM_ENC];
  logic [31:0] delta_q [NUM_ENC];
  logic [NUM_ENC-1:0] b_q;
  logic [1:0] wdir_q [NUM_ENC];

  logic [2:0]  state_q;
  logic        pass_q;
  enc_sel_t    sel_q;
  unit_t       unit_q;
  logic [5:0]  cnt_q;
  logic [59:0] prod_q, mcand_q;
  logic [26:0] mplier_q;
  logic [39:0] div_q, rem_q;
  logic        neg_q;
  value_t      pos_w_q, spd_w_q, pos_o_q, spd_o_q;
  dir_code_t   dir_q, dir_o_q;
  logic        res_valid_q;

  logic accept;
  assign accept    = req.valid && req.ready;
  assign req.ready = (state_q == ST_IDLE);

  assign res.valid          = res_valid_q;
  assign res.position_value = pos_o_q;
  assign res.speed_value    = spd_o_q;
  assign res.direction_code = dir_o_q;

  // Operand preparation for the current pass.
  logic [15:0] ppr_eff, ivl_eff;
  logic [23:0] base, base_n;
  logic [26:0] k_unit, k_1000;
  logic signed [32:0] sum;
  logic [32:0] mag;
  logic [39:0] div_spd;

  always_comb begin
    ppr_eff = (ppr_q == 16'd0) ? 16'd1 : ppr_q;
    ivl_eff = (ivl_q == 16'd0) ? 16'd1 : ivl_q;
    case (unit_q)
      UNIT_COUNTS: begin base = 24'd1; k_unit = K_COUNTS; end
      UNIT_DEG:    begin base = {8'd0, ppr_eff}; k_unit = K_DEG; end
      UNIT_CM:     begin base = {8'd0, ppr_eff}; k_unit = {11'd0, circ_q}; end
      default: begin
        base   = ({8'd0, ppr_eff} << 6) + ({8'd0, ppr_eff} << 5) + ({8'd0, ppr_eff} << 2);
        k_unit = {11'd0, circ_q};
      end
    endcase
    base_n  = (sel_q == SEL_BOTH) ? (base << 1) : base;
    k_1000  = (k_unit << 10) - (k_unit << 4) - (k_unit << 3);
    div_spd = base_n * ivl_eff;
    case (sel_q)
      SEL_ENC0: sum = pass_q ? 33'(signed'(delta_q[0])) : 33'(signed'(pc_q[0]));
      SEL_ENC1: sum = pass_q ? 33'(signed'(delta_q[1])) : 33'(signed'(pc_q[1]));
      SEL_BOTH: sum = pass_q ? 33'(signed'(delta_q[0])) + 33'(signed'(delta_q[1]))
                             : 33'(signed'(pc_q[0])) + 33'(signed'(pc_q[1]));
      default:  sum = '0;
    endcase
    mag = sum[32] ? 33'(-sum) : 33'(sum);
  end

  // Shared adder: accumulate in the multiply, trial subtract in the divide.
  logic [59:0] alu_a, alu_b, alu_s;
  logic        alu_ci;
  logic [40:0] trial;
  always_comb begin
    trial = {rem_q, prod_q[59]};
    if (state_q == ST_DIV) begin
      alu_a  = {19'd0, trial};
      alu_b  = ~{20'd0, div_q};
      alu_ci = 1'b1;
    end else begin
      alu_a  = prod_q;
      alu_b  = mcand_q;
      alu_ci = 1'b0;
    end
    alu_s = alu_a + alu_b + {59'd0, alu_ci};
  end

  logic [47:0] sat_v;
  always_comb begin
    if (!neg_q) sat_v = (prod_q > POS_LIM) ? POS_LIM[47:0] : prod_q[47:0];
    else        sat_v = (prod_q > NEG_LIM) ? NEG_LIM[47:0] : 48'(-prod_q[47:0]);
  end

  dir_code_t dir_sel;
  always_comb begin
    case (sel_q)
      SEL_ENC0, SEL_ENC1: begin
        case (wdir_q[sel_q[0]])
          WDIR_CW:  dir_sel = DIR_CW;
          WDIR_CCW: dir_sel = DIR_CCW;
          default:  dir_sel = DIR_UNKNOWN;
        endcase
      end
      SEL_BOTH: begin
        if (wdir_q[0] == WDIR_CW && wdir_q[1] == WDIR_CW)        dir_sel = DIR_FWD;
        else if (wdir_q[0] == WDIR_CCW && wdir_q[1] == WDIR_CCW) dir_sel = DIR_BWD;
        else if (wdir_q[0] == WDIR_CCW && wdir_q[1] == WDIR_CW)  dir_sel = DIR_TURN_R;
        else if (wdir_q[0] == WDIR_CW && wdir_q[1] == WDIR_CCW)  dir_sel = DIR_TURN_L;
        else                                                      dir_sel = DIR_UNKNOWN;
      end
      default: dir_sel = DIR_UNKNOWN;
    endcase
  end

  // Configuration and encoder state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppr_q  <= PPR_RST;
      circ_q <= CIRC_RST;
      ivl_q  <= IVL_RST;
      cw_q   <= '1;
      b_q    <= '0;
      for (int i = 0; i < NUM_ENC; i++) begin
        pc_q[i]    <= '0;
        last_q[i]  <= '0;
        delta_q[i] <= '0;
        wdir_q[i]  <= WDIR_UNK;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_PPR:  ppr_q   <= cfg_wdata_i;
          CFG_CIRC: circ_q  <= cfg_wdata_i;
          CFG_IVL:  ivl_q   <= cfg_wdata_i;
          CFG_CW0:  cw_q[0] <= cfg_wdata_i[0];
          CFG_CW1:  cw_q[1] <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (accept) begin
        unique case (req.req_type)
          REQ_A_RISE: begin
            if (req.encoder_sel == SEL_ENC0 || req.encoder_sel == SEL_ENC1) begin
              if (!b_q[req.encoder_sel[0]]) begin
                pc_q[req.encoder_sel[0]]   <= pc_q[req.encoder_sel[0]] + 32'd1;
                wdir_q[req.encoder_sel[0]] <= cw_q[req.encoder_sel[0]] ? WDIR_CW : WDIR_CCW;
              end else begin
                pc_q[req.encoder_sel[0]]   <= pc_q[req.encoder_sel[0]] - 32'd1;
                wdir_q[req.encoder_sel[0]] <= cw_q[req.encoder_sel[0]] ? WDIR_CCW : WDIR_CW;
              end
            end
          end
          REQ_B_EDGE: begin
            if (req.encoder_sel == SEL_ENC0 || req.encoder_sel == SEL_ENC1)
              b_q[req.encoder_sel[0]] <= ~b_q[req.encoder_sel[0]];
          end
          REQ_TICK: begin
            for (int i = 0; i < NUM_ENC; i++) begin
              delta_q[i] <= pc_q[i] - last_q[i];
              last_q[i]  <= pc_q[i];
            end
          end
          REQ_CLEAR: begin
            if (req.encoder_sel == SEL_ENC0 || req.encoder_sel == SEL_ENC1)
              pc_q[req.encoder_sel[0]] <= '0;
            else if (req.encoder_sel == SEL_BOTH)
              for (int i = 0; i < NUM_ENC; i++) pc_q[i] <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pass_q      <= 1'b0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
      sel_q       <= SEL_ENC0;
      unit_q      <= UNIT_COUNTS;
    end else begin
      // The hand-off state refills the result register itself.
      if (res_valid_q && res.ready && state_q != ST_DONE) res_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            sel_q   <= req.encoder_sel;
            unit_q  <= req.unit_format;
            pass_q  <= 1'b0;
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          cnt_q   <= MUL_STEPS;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          if (cnt_q == 6'd1) begin
            cnt_q   <= DIV_STEPS;
            state_q <= ST_DIV;
          end else begin
            cnt_q <= cnt_q - 6'd1;
          end
        end
        ST_DIV: begin
          if (cnt_q == 6'd1) state_q <= ST_SAT;
          else cnt_q <= cnt_q - 6'd1;
        end
        ST_SAT: begin
          if (!pass_q) begin
            pass_q  <= 1'b1;
            state_q <= ST_LOAD;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!res_valid_q || res.ready) begin
            res_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_LOAD: begin
        prod_q   <= '0;
        mcand_q  <= {27'd0, mag};
        mplier_q <= pass_q ? k_1000 : k_unit;
        div_q    <= pass_q ? div_spd : {16'd0, base_n};
        rem_q    <= '0;
        neg_q    <= sum[32];
        dir_q    <= dir_sel;
      end
      ST_MUL: begin
        if (mplier_q[0]) prod_q <= alu_s;
        mcand_q  <= mcand_q << 1;
        mplier_q <= mplier_q >> 1;
      end
      ST_DIV: begin
        // Non-negative difference means the trial subtract fits.
        if (!alu_s[59]) begin
          rem_q  <= alu_s[39:0];
          prod_q <= {prod_q[58:0], 1'b1};
        end else begin
          rem_q  <= trial[39:0];
          prod_q <= {prod_q[58:0], 1'b0};
        end
      end
      ST_SAT: begin
        if (!pass_q) pos_w_q <= sat_v;
        else         spd_w_q <= sat_v;
      end
      ST_DONE: begin
        if (!res_valid_q || res.ready) begin
          pos_o_q <= pos_w_q;
          spd_o_q <= spd_w_q;
          dir_o_q <= dir_q;
        end
      end
      default: ;
    endcase
  end

  `QEPS_ASSERT_NEXT(a_busy_after_req, accept, state_q != ST_IDLE)
  `QEPS_ASSERT(a_rem_below_div, (state_q == ST_DIV) |-> (rem_q < div_q))
  `QEPS_ASSERT_NEXT(a_sel3_zero,
    state_q == ST_DONE && sel_q == SEL_NONE && (!res_valid_q || res.ready),
    pos_o_q == '0 && spd_o_q == '0 && dir_o_q == DIR_UNKNOWN)

endmodule
`default_nettype wire
